@@ src/prtl_pkg.sv @@
// Shared types and constants for the pump run timer with lockout.
package prtl_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [TimeW-1:0] MaxRunReset = TimeW'(60000);
  localparam logic [TimeW-1:0] LockoutReset = TimeW'(60000);

  typedef enum logic [1:0] {
    FuncTick  = 2'd0,
    FuncStart = 2'd1,
    FuncStop  = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StBadState = 2'd1,
    StBadArg   = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgEnable     = 2'd0,
    CfgMaxRun     = 2'd1,
    CfgLockout    = 2'd2,
    CfgActiveHigh = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic             enable;
    logic [TimeW-1:0] max_run_ms;
    logic [TimeW-1:0] lockout_ms;
    logic             active_high;
  } cfg_t;

  typedef struct packed {
    logic             running;
    logic             lockout;
    logic             stopped_before;
    logic [TimeW-1:0] run_left;
    logic [TimeW-1:0] since_stop;
  } state_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             drive_level;
    logic             is_running;
    logic             in_lockout;
    logic [TimeW-1:0] time_left_ms;
  } result_t;

endpackage

@@ src/prtl_if.sv @@
// Valid/ready channel interfaces for request and result beats.
interface prtl_in_if;
  import prtl_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       func;
  logic [TimeW-1:0] run_time_ms;
  modport source (output valid, func, run_time_ms, input ready);
  modport sink (input valid, func, run_time_ms, output ready);
endinterface

interface prtl_out_if;
  import prtl_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic             drive_level;
  logic             is_running;
  logic             in_lockout;
  logic [TimeW-1:0] time_left_ms;
  modport source (output valid, status, drive_level, is_running, in_lockout, time_left_ms,
                  input ready);
  modport sink (input valid, status, drive_level, is_running, in_lockout, time_left_ms,
                output ready);
endinterface

@@ src/prtl_core.sv @@
// Next-state and result logic for one request beat.
module prtl_core import prtl_pkg::*; (
  input  cfg_t             cfg_i,
  input  state_t           state_i,
  input  logic [1:0]       func_i,
  input  logic [TimeW-1:0] run_time_ms_i,
  output state_t           state_o,
  output result_t          result_o
);

  logic [TimeW-1:0] run_dec;
  logic [TimeW-1:0] since_inc;
  logic [1:0]       status;
  state_t           nxt;

  assign run_dec   = (state_i.run_left != '0) ? state_i.run_left - TimeW'(1) : state_i.run_left;
  assign since_inc = (state_i.since_stop < cfg_i.lockout_ms) ?
                     state_i.since_stop + TimeW'(1) : state_i.since_stop;

  always_comb begin
    nxt    = state_i;
    status = StOk;
    unique case (func_i)
      FuncTick: begin
        nxt.run_left   = run_dec;
        nxt.since_stop = since_inc;
        if (cfg_i.enable) begin
          if (state_i.running && run_dec == '0) begin
            nxt.running        = 1'b0;
            nxt.run_left       = '0;
            nxt.since_stop     = '0;
            nxt.stopped_before = 1'b1;
            nxt.lockout        = 1'b1;
          end else if (!state_i.running && state_i.stopped_before &&
                       since_inc >= cfg_i.lockout_ms) begin
            nxt.lockout = 1'b0;
          end
        end
      end
      FuncStart: begin
        if (!cfg_i.enable) begin
          status = StBadState;
        end else if (run_time_ms_i == '0 || run_time_ms_i > cfg_i.max_run_ms) begin
          status = StBadArg;
        end else if (state_i.running) begin
          status = StBadState;
        end else if (state_i.stopped_before && state_i.since_stop < cfg_i.lockout_ms) begin
          nxt.lockout = 1'b1;
          status      = StBadState;
        end else begin
          nxt.running  = 1'b1;
          nxt.lockout  = 1'b0;
          nxt.run_left = run_time_ms_i;
        end
      end
      FuncStop: begin
        if (cfg_i.enable && state_i.running) begin
          nxt.running        = 1'b0;
          nxt.run_left       = '0;
          nxt.since_stop     = '0;
          nxt.stopped_before = 1'b1;
          nxt.lockout        = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign state_o                = nxt;
  assign result_o.status        = status;
  assign result_o.drive_level   = ~(nxt.running ^ cfg_i.active_high);
  assign result_o.is_running    = nxt.running;
  assign result_o.in_lockout    = nxt.lockout;
  assign result_o.time_left_ms  = nxt.running ? nxt.run_left : '0;

endmodule

@@ src/pump_run_timer_with_lockout.sv @@
// Top level: pump run timer with minimum off time after each stop.
//
// Request channel (in_ch) carries tick, start or stop beats; each one gives
// exactly one result beat on out_ch with status, drive level, running and
// lockout flags and remaining run time.
// Latency: a result is valid the cycle after its request is accepted.
// Throughput: one request per cycle unless stalled; state update and result
// are one pass of logic between the state registers and the result register.
// When the receiver stalls, the result register holds and in_ch.ready drops
// until the pending result is taken; it stays high while the result register
// is empty or being emptied in the same cycle.
// Configuration: cfg_we_i writes register cfg_idx_i (enable, max run,
// lockout, polarity) with cfg_data_i; write only while idle.
// Reset: pump stopped, never stopped before, enable off, limits 60000 ms,
// active-high drive; no result pending.
module pump_run_timer_with_lockout import prtl_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [TimeW-1:0]   cfg_data_i,
  prtl_in_if.sink            in_ch,
  prtl_out_if.source         out_ch
);

  cfg_t    cfg_q;
  state_t  state_q, state_d;
  result_t res_q, res_d;
  logic    out_valid_q;
  logic    in_beat;

  assign in_ch.ready = !out_valid_q || out_ch.ready;
  assign in_beat     = in_ch.valid && in_ch.ready;

  prtl_core u_core (
    .cfg_i         (cfg_q),
    .state_i       (state_q),
    .func_i        (in_ch.func),
    .run_time_ms_i (in_ch.run_time_ms),
    .state_o       (state_d),
    .result_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable      <= 1'b0;
      cfg_q.max_run_ms  <= MaxRunReset;
      cfg_q.lockout_ms  <= LockoutReset;
      cfg_q.active_high <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgEnable:     cfg_q.enable      <= cfg_data_i[0];
        CfgMaxRun:     cfg_q.max_run_ms  <= cfg_data_i;
        CfgLockout:    cfg_q.lockout_ms  <= cfg_data_i;
        CfgActiveHigh: cfg_q.active_high <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_beat) begin
        state_q <= state_d;
      end
      if (in_beat) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      res_q <= res_d;
    end
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.status       = res_q.status;
  assign out_ch.drive_level  = res_q.drive_level;
  assign out_ch.is_running   = res_q.is_running;
  assign out_ch.in_lockout   = res_q.in_lockout;
  assign out_ch.time_left_ms = res_q.time_left_ms;

  a_beat_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> out_ch.valid)
    else $error("accepted beat gave no result");

  a_run_excl_lockout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.is_running |-> !out_ch.in_lockout)
    else $error("running and lockout both set");

  a_stopped_no_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && !out_ch.is_running |-> out_ch.time_left_ms == '0)
    else $error("time left shown while stopped");

  a_state_matches_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> out_ch.is_running == state_q.running && out_ch.in_lockout == state_q.lockout)
    else $error("result flags differ from state");

endmodule
